// ===== design/psmd_pkg.sv =====
// Shared constants for the PS/2 mouse packet decoder.
package psmd_pkg;

    // Width of the motion accumulators unless overridden on the top level.
    localparam int ACCUM_WIDTH_DEFAULT = 16;

    // Fixed widths of the byte and result ports and of the internal button and phase fields.
    localparam int BYTE_W   = 8;
    localparam int TOTAL_W  = 16;
    localparam int BUTTON_W = 5;
    localparam int PHASE_W  = 2;

    // Configuration port shape.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_MODE        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_BUTTON_MODE = 2'd2;

    // Packet phase codes.
    localparam logic [PHASE_W-1:0] PH_FLAG  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_X     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_Y     = 2'd2;
    localparam logic [PHASE_W-1:0] PH_FOURTH = 2'd3;

    // Bit positions inside received bytes.
    localparam int FLAG_MARK_BIT = 3;   // always set in a valid flag byte
    localparam int BTN4_SRC_BIT  = 4;   // fourth byte, extra-button mode
    localparam int BTN5_SRC_BIT  = 5;   // fourth byte, extra-button mode
    localparam int Z_NIBBLE_W    = 4;   // unsigned wheel nibble in the fourth byte

    // Bit positions inside the button state vector.
    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_MIDDLE = 2;
    localparam int BTN_FOURTH = 3;
    localparam int BTN_FIFTH  = 4;

endpackage

// ===== design/ps2_mouse_packet_decoder.sv =====
// PS/2 mouse packet decoder: byte phase tracking, buttons and saturating motion totals.
// Throughput: one byte per cycle; the input register takes one more byte while a result
// waits, then stalls. The input register feeds the update logic, which loads the state
// and result registers.
// Reset clears the configuration, phase, buttons, accumulators and both valid flags.
// Result fields show the decoder state right after the byte was applied.
module ps2_mouse_packet_decoder #(
    parameter int ACCUM_WIDTH = psmd_pkg::ACCUM_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [psmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [psmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Byte input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [psmd_pkg::BYTE_W-1:0]         rx_byte,
    // Result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                left_button,
    output logic                                right_button,
    output logic                                middle_button,
    output logic                                fourth_button,
    output logic                                fifth_button,
    output logic signed [psmd_pkg::TOTAL_W-1:0] x_total,
    output logic signed [psmd_pkg::TOTAL_W-1:0] y_total,
    output logic signed [psmd_pkg::TOTAL_W-1:0] z_total,
    output logic                                packet_done
);
    import psmd_pkg::*;

    localparam int SUM_W   = ACCUM_WIDTH + 1;
    localparam int DELTA_W = BYTE_W + 1;
    localparam int EXT_W   = (ACCUM_WIDTH > TOTAL_W) ? ACCUM_WIDTH : TOTAL_W;

    localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

    // Add a small signed delta and clamp to the accumulator range.
    function automatic logic signed [ACCUM_WIDTH-1:0] sat_add(
        input logic signed [ACCUM_WIDTH-1:0] acc,
        input logic signed [DELTA_W-1:0]     delta
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [ACCUM_WIDTH-1:0] res;
        sum = SUM_W'(acc) + SUM_W'(delta);
        if (sum[SUM_W-1] != sum[SUM_W-2])
        begin
            res = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            res = sum[ACCUM_WIDTH-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic mouse_enable_reg;
    logic wheel_mode_reg;
    logic extra_button_mode_reg;

    // Input register stage.
    logic              hold_valid_reg;
    logic [BYTE_W-1:0] hold_byte_reg;

    // Decoder state, which also serves as the result register.
    logic [PHASE_W-1:0]             phase_reg;
    logic [PHASE_W-1:0]             phase_next;
    logic [BUTTON_W-1:0]            button_reg;
    logic [BUTTON_W-1:0]            button_next;
    logic signed [ACCUM_WIDTH-1:0]  x_acc_reg;
    logic signed [ACCUM_WIDTH-1:0]  x_acc_next;
    logic signed [ACCUM_WIDTH-1:0]  y_acc_reg;
    logic signed [ACCUM_WIDTH-1:0]  y_acc_next;
    logic signed [ACCUM_WIDTH-1:0]  z_acc_reg;
    logic signed [ACCUM_WIDTH-1:0]  z_acc_next;
    logic                           done_reg;
    logic                           done_next;
    logic                           out_valid_reg;

    logic                      out_free;
    logic                      load;
    logic signed [DELTA_W-1:0] byte_delta;
    logic signed [DELTA_W-1:0] nibble_delta;

    // The result register is free when empty or when its transaction completes now.
    assign out_free = !out_valid_reg || !out_stall;
    assign load     = hold_valid_reg && out_free;
    assign in_stall = hold_valid_reg && !out_free;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mouse_enable_reg      <= 1'b0;
            wheel_mode_reg        <= 1'b0;
            extra_button_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MOUSE_ENABLE:      mouse_enable_reg      <= cfg_data[0];
                REG_WHEEL_MODE:        wheel_mode_reg        <= cfg_data[0];
                REG_EXTRA_BUTTON_MODE: extra_button_mode_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Input register: take a byte whenever the held one moves on or none is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            hold_byte_reg <= rx_byte;
        end
    end

    // Motion deltas from the held byte.
    assign byte_delta   = DELTA_W'(signed'(hold_byte_reg));
    assign nibble_delta = DELTA_W'({1'b0, hold_byte_reg[Z_NIBBLE_W-1:0]});

    // Packet phase decoding and state update.
    always_comb
    begin
        phase_next  = phase_reg;
        button_next = button_reg;
        x_acc_next  = x_acc_reg;
        y_acc_next  = y_acc_reg;
        z_acc_next  = z_acc_reg;
        done_next   = 1'b0;
        if (!mouse_enable_reg)
        begin
            phase_next = PH_FLAG;
        end
        else
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    if (hold_byte_reg[FLAG_MARK_BIT])
                    begin
                        button_next[BTN_LEFT]   = hold_byte_reg[BTN_LEFT];
                        button_next[BTN_RIGHT]  = hold_byte_reg[BTN_RIGHT];
                        button_next[BTN_MIDDLE] = hold_byte_reg[BTN_MIDDLE];
                        phase_next = PH_X;
                    end
                end
                PH_X:
                begin
                    x_acc_next = sat_add(x_acc_reg, byte_delta);
                    phase_next = PH_Y;
                end
                PH_Y:
                begin
                    y_acc_next = sat_add(y_acc_reg, byte_delta);
                    if (wheel_mode_reg)
                    begin
                        phase_next = PH_FOURTH;
                    end
                    else
                    begin
                        phase_next = PH_FLAG;
                        done_next  = 1'b1;
                    end
                end
                PH_FOURTH:
                begin
                    if (extra_button_mode_reg)
                    begin
                        button_next[BTN_FOURTH] = hold_byte_reg[BTN4_SRC_BIT];
                        button_next[BTN_FIFTH]  = hold_byte_reg[BTN5_SRC_BIT];
                        z_acc_next = sat_add(z_acc_reg, nibble_delta);
                    end
                    else
                    begin
                        z_acc_next = sat_add(z_acc_reg, -byte_delta);
                    end
                    phase_next = PH_FLAG;
                    done_next  = 1'b1;
                end
                default:
                begin
                    phase_next = PH_FLAG;
                end
            endcase
        end
    end

    // State and result registers, loaded once per byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAG;
            button_reg    <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            z_acc_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg  <= phase_next;
                button_reg <= button_next;
                x_acc_reg  <= x_acc_next;
                y_acc_reg  <= y_acc_next;
                z_acc_reg  <= z_acc_next;
                done_reg   <= done_next;
            end
            if (out_free)
            begin
                out_valid_reg <= load;
            end
        end
    end

    // Result ports: the low bits of the sign-extended accumulators.
    logic [EXT_W-1:0] x_ext;
    logic [EXT_W-1:0] y_ext;
    logic [EXT_W-1:0] z_ext;

    assign x_ext = EXT_W'(x_acc_reg);
    assign y_ext = EXT_W'(y_acc_reg);
    assign z_ext = EXT_W'(z_acc_reg);

    assign out_valid     = out_valid_reg;
    assign left_button   = button_reg[BTN_LEFT];
    assign right_button  = button_reg[BTN_RIGHT];
    assign middle_button = button_reg[BTN_MIDDLE];
    assign fourth_button = button_reg[BTN_FOURTH];
    assign fifth_button  = button_reg[BTN_FIFTH];
    assign x_total       = x_ext[TOTAL_W-1:0];
    assign y_total       = y_ext[TOTAL_W-1:0];
    assign z_total       = z_ext[TOTAL_W-1:0];
    assign packet_done   = done_reg;

    // A completed packet always leaves the decoder waiting for a flag byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (phase_reg == PH_FLAG))
        else $error("packet_done shown while phase is not the flag phase");

    // The input side only stalls while a byte is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> hold_valid_reg)
        else $error("input stalled with the input register empty");

    // A byte taken while the mouse is disabled resets the phase and reports no packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && !mouse_enable_reg) |=> ((phase_reg == PH_FLAG) && !done_reg))
        else $error("disabled mouse did not return to the flag phase");

    // Accumulators and buttons change only when a byte is applied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> ($stable(x_acc_reg) && $stable(y_acc_reg) && $stable(z_acc_reg)
                   && $stable(button_reg)))
        else $error("decoder state changed without a byte being applied");

endmodule
